/* hdl/pfl_pkg.sv */
package pfl_pkg;

    // Field widths
    localparam int POS_W  = 32;   // s15.16 positions
    localparam int NRM_W  = 20;   // s3.16 input normal
    localparam int COL_W  = 18;   // u2.16 colour out
    localparam int UNIT_W = 18;   // signed unit vector component, -1.0..1.0
    localparam int Q_W    = 17;   // u1.16, 0..1.0
    localparam int FRAC_W = 16;

    // Normaliser internals
    localparam int VEC_W      = 36;            // raw vector component into a normaliser
    localparam int MAG_W      = 30;            // largest magnitude aligned to [2^29, 2^30)
    localparam int SQR_W      = 2 * MAG_W;     // one squared component
    localparam int SQ_W       = SQR_W + 2;     // sum of three squares
    localparam int SQRT_STEPS = SQ_W / 2;      // one result bit per stage
    localparam int ROOT_W     = SQRT_STEPS + 1;
    localparam int DIV_STEPS  = Q_W;           // one quotient bit per stage
    localparam int NORM_LAT   = 7 + SQRT_STEPS + DIV_STEPS;

    localparam int SHININESS = 40;

    localparam logic [Q_W-1:0] ONE_U = Q_W'(1 << FRAC_W);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z  = 3'd5;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [NRM_W-1:0]  nrm_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef logic [Q_W-1:0]           ufrac_t;
    typedef logic [COL_W-1:0]         col_t;

    // (a * b + 0.5) >> 16 for two u1.16 values; result stays within 1.0
    function automatic ufrac_t round_mul(input ufrac_t a, input ufrac_t b);
        logic [2*Q_W:0] acc;
        acc = {1'b0, (2*Q_W)'(a) * (2*Q_W)'(b)} + (2*Q_W+1)'(1 << (FRAC_W - 1));
        return acc[FRAC_W+Q_W-1:FRAC_W];
    endfunction

    // Dot product sum of unit vectors clamped to [0, 1.0]
    function automatic ufrac_t clamp_dot(input logic signed [VEC_W-1:0] s);
        logic [VEC_W-FRAC_W-1:0] q;
        q = s[VEC_W-1:FRAC_W];
        if (s <= 0) begin
            return '0;
        end else if (q > (VEC_W-FRAC_W)'(ONE_U)) begin
            return ONE_U;
        end else begin
            return q[Q_W-1:0];
        end
    endfunction

endpackage

/* hdl/pfl_norm3.sv */
module pfl_norm3 (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_vld,
    input  pfl_pkg::vec_t   in_x,
    input  pfl_pkg::vec_t   in_y,
    input  pfl_pkg::vec_t   in_z,
    output logic            out_vld,
    output pfl_pkg::unit_t  out_x,
    output pfl_pkg::unit_t  out_y,
    output pfl_pkg::unit_t  out_z
);
    import pfl_pkg::*;

    localparam int MSB_W  = $clog2(VEC_W);
    localparam int DREM_W = MAG_W + 1;
    localparam logic [MSB_W-1:0] TOP_POS = MSB_W'(MAG_W - 1);

    typedef struct packed {
        logic                  zero;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } side_t;

    vec_t in_v [3];

    // front end: magnitude, alignment, squares
    logic [2:0][VEC_W-1:0] mag1_reg, mag1_next, mag2_reg;
    logic [2:0]            neg1_reg, neg1_next, neg2_reg, neg3_reg;
    logic                  zero2_reg, zero2_next, zero3_reg;
    logic                  right2_reg, right2_next;
    logic [MSB_W-1:0]      amt2_reg, amt2_next;
    logic [2:0][MAG_W-1:0] mag3_reg, mag3_next;
    logic [2:0][SQR_W-1:0] sq4_reg, sq4_next;
    side_t                 side4_reg;

    // square root pipeline
    logic [SQ_W-1:0]   sx_reg    [SQRT_STEPS];
    logic [SQ_W-1:0]   sx_next   [SQRT_STEPS];
    logic [ROOT_W-1:0] srem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] srem_next [SQRT_STEPS];
    logic [ROOT_W-1:0] sroot_reg [SQRT_STEPS+1];
    logic [ROOT_W-1:0] sroot_next[SQRT_STEPS+1];
    side_t             sside_reg [SQRT_STEPS+1];
    side_t             sside_next[SQRT_STEPS+1];
    logic [ROOT_W+1:0] srem_t    [SQRT_STEPS];
    logic [ROOT_W+1:0] strial    [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] sge;

    // divider pipeline
    logic [2:0][DREM_W-1:0] drem_reg  [DIV_STEPS];
    logic [2:0][DREM_W-1:0] drem_next [DIV_STEPS];
    logic [2:0][DREM_W-1:0] drem_new  [DIV_STEPS];
    logic [DREM_W-1:0]      droot_reg [DIV_STEPS];
    logic [DREM_W-1:0]      droot_next[DIV_STEPS];
    logic [2:0][Q_W-1:0]    dq_reg    [DIV_STEPS+1];
    logic [2:0][Q_W-1:0]    dq_next   [DIV_STEPS+1];
    logic [2:0]             dneg_reg  [DIV_STEPS+1];
    logic [2:0]             dneg_next [DIV_STEPS+1];
    logic                   dzero_reg [DIV_STEPS+1];
    logic                   dzero_next[DIV_STEPS+1];
    logic [2:0]             dlsb_reg, dlsb_next;

    unit_t out_reg  [3];
    unit_t out_next [3];
    logic  vld_reg  [NORM_LAT];

    assign in_v[0] = in_x;
    assign in_v[1] = in_y;
    assign in_v[2] = in_z;

    // stage 1: sign and magnitude
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            neg1_next[c] = in_v[c][VEC_W-1];
            mag1_next[c] = neg1_next[c] ? VEC_W'(-in_v[c]) : VEC_W'(in_v[c]);
        end
    end

    // stage 2: leading one of the largest magnitude, shift needed to align
    always_comb begin
        logic [VEC_W-1:0] or_all;
        logic [MSB_W-1:0] msb;
        or_all = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        msb    = '0;
        for (int i = 0; i < VEC_W; i++) begin
            if (or_all[i]) begin
                msb = MSB_W'(i);
            end
        end
        zero2_next  = (or_all == '0);
        right2_next = (msb >= TOP_POS);
        amt2_next   = right2_next ? (msb - TOP_POS) : (TOP_POS - msb);
    end

    // stage 3: align all three together
    always_comb begin
        logic [VEC_W-1:0] sh;
        for (int c = 0; c < 3; c++) begin
            sh = right2_reg ? (mag2_reg[c] >> amt2_reg) : (mag2_reg[c] << amt2_reg);
            mag3_next[c] = sh[MAG_W-1:0];
        end
    end

    // stage 4: squares
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sq4_next[c] = SQR_W'(mag3_reg[c]) * SQR_W'(mag3_reg[c]);
        end
    end

    // square root, one result bit per stage (restoring)
    always_comb begin
        for (int j = 0; j < SQRT_STEPS; j++) begin
            srem_t[j] = {srem_reg[j], sx_reg[j][SQ_W-1 -: 2]};
            strial[j] = {sroot_reg[j], 2'b01};
            sge[j]    = (srem_t[j] >= strial[j]);
        end
    end

    always_comb begin
        sx_next[0]    = SQ_W'(sq4_reg[0]) + SQ_W'(sq4_reg[1]) + SQ_W'(sq4_reg[2]);
        srem_next[0]  = '0;
        sroot_next[0] = '0;
        sside_next[0] = side4_reg;
        for (int j = 1; j < SQRT_STEPS; j++) begin
            sx_next[j]   = sx_reg[j-1] << 2;
            srem_next[j] = sge[j-1] ? ROOT_W'(srem_t[j-1] - strial[j-1])
                                    : srem_t[j-1][ROOT_W-1:0];
        end
        for (int j = 1; j <= SQRT_STEPS; j++) begin
            sroot_next[j] = {sroot_reg[j-1][ROOT_W-2:0], sge[j-1]};
            sside_next[j] = sside_reg[j-1];
        end
    end

    // long division mag * 2^16 / root, one quotient bit per stage
    always_comb begin
        logic [DREM_W:0] drem2;
        logic            dge;
        droot_next[0] = sroot_reg[SQRT_STEPS][DREM_W-1:0];
        dq_next[0]    = '0;
        dneg_next[0]  = sside_reg[SQRT_STEPS].neg;
        dzero_next[0] = sside_reg[SQRT_STEPS].zero;
        for (int c = 0; c < 3; c++) begin
            drem_next[0][c] = DREM_W'(sside_reg[SQRT_STEPS].mag[c][MAG_W-1:1]);
            dlsb_next[c]    = sside_reg[SQRT_STEPS].mag[c][0];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int c = 0; c < 3; c++) begin
                drem2 = {drem_reg[k][c], (k == 0) ? dlsb_reg[c] : 1'b0};
                dge   = (drem2 >= {1'b0, droot_reg[k]});
                drem_new[k][c]  = dge ? DREM_W'(drem2 - {1'b0, droot_reg[k]})
                                      : drem2[DREM_W-1:0];
                dq_next[k+1][c] = {dq_reg[k][c][Q_W-2:0], dge};
            end
            dneg_next[k+1]  = dneg_reg[k];
            dzero_next[k+1] = dzero_reg[k];
        end
        for (int k = 1; k < DIV_STEPS; k++) begin
            drem_next[k]  = drem_new[k-1];
            droot_next[k] = droot_reg[k-1];
        end
    end

    // sign back on; zero vector gives zero
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (dzero_reg[DIV_STEPS]) begin
                out_next[c] = '0;
            end else if (dneg_reg[DIV_STEPS][c]) begin
                out_next[c] = -UNIT_W'(dq_reg[DIV_STEPS][c]);
            end else begin
                out_next[c] = UNIT_W'(dq_reg[DIV_STEPS][c]);
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg   <= mag1_next;
            neg1_reg   <= neg1_next;
            mag2_reg   <= mag1_reg;
            neg2_reg   <= neg1_reg;
            zero2_reg  <= zero2_next;
            right2_reg <= right2_next;
            amt2_reg   <= amt2_next;
            mag3_reg   <= mag3_next;
            neg3_reg   <= neg2_reg;
            zero3_reg  <= zero2_reg;
            sq4_reg    <= sq4_next;
            side4_reg  <= '{zero: zero3_reg, neg: neg3_reg, mag: mag3_reg};
            sx_reg     <= sx_next;
            srem_reg   <= srem_next;
            sroot_reg  <= sroot_next;
            sside_reg  <= sside_next;
            drem_reg   <= drem_next;
            droot_reg  <= droot_next;
            dq_reg     <= dq_next;
            dneg_reg   <= dneg_next;
            dzero_reg  <= dzero_next;
            dlsb_reg   <= dlsb_next;
            out_reg    <= out_next;
        end
    end

    // valid travels alongside
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '{default: 1'b0};
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < NORM_LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign out_vld = vld_reg[NORM_LAT-1];
    assign out_x   = out_reg[0];
    assign out_y   = out_reg[1];
    assign out_z   = out_reg[2];

endmodule

/* hdl/pfl_specular.sv */
module pfl_specular (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  pfl_pkg::ufrac_t  in_s,
    input  pfl_pkg::ufrac_t  in_d,
    input  pfl_pkg::ufrac_t  in_td,
    output logic             out_vld,
    output pfl_pkg::col_t    out_red,
    output pfl_pkg::col_t    out_green,
    output pfl_pkg::col_t    out_blue
);
    import pfl_pkg::*;

    ufrac_t p_reg  [SHININESS];
    ufrac_t s_reg  [SHININESS];
    ufrac_t d_reg  [SHININESS];
    ufrac_t td_reg [SHININESS];
    logic   vld_reg[SHININESS+1];
    col_t   red_reg, green_reg;

    // one rounded multiply per stage: p = s^k after stage k
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0]  <= round_mul(ONE_U, in_s);
            s_reg[0]  <= in_s;
            d_reg[0]  <= in_d;
            td_reg[0] <= in_td;
            for (int k = 1; k < SHININESS; k++) begin
                p_reg[k]  <= round_mul(p_reg[k-1], s_reg[k-1]);
                s_reg[k]  <= s_reg[k-1];
                d_reg[k]  <= d_reg[k-1];
                td_reg[k] <= td_reg[k-1];
            end
            // diffuse plus specular; red and blue are equal
            red_reg   <= COL_W'(td_reg[SHININESS-1]) + COL_W'(p_reg[SHININESS-1]);
            green_reg <= COL_W'(d_reg[SHININESS-1]) + COL_W'(p_reg[SHININESS-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '{default: 1'b0};
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k <= SHININESS; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign out_vld   = vld_reg[SHININESS];
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = red_reg;

endmodule

/* hdl/phong_fragment_lighting_unit.sv */
// Per-fragment Phong lighting with a white point light and a white highlight.
// Input channel (s_valid/s_ready): one fragment request per cycle while s_ready
// is high, carrying world position (s15.16) and interpolated normal (s3.16).
// Result channel (m_valid/m_ready): red, green_out, blue as u2.16, 0..2.0.
// Configuration channel (cfg_valid/cfg_ready, always ready): register index
// 0..2 camera x/y/z, 3..5 light x/y/z, s15.16; other indexes are ignored.
// Write configuration only while no request is in flight.
// Throughput: one request per cycle while s_ready is high. The delay from the
// accepting edge to m_valid is set by two normaliser passes in series (55
// stages each: 31 square-root stages and 17 divider stages) and the 40-stage
// specular power chain.
// Stalls: the whole pipeline advances together. The output register is backed
// by a one-entry skid buffer, so input stays ready while a result waits; once
// the skid holds a result as well, s_ready drops until m_ready returns.
// Reset (aresetn, synchronous, active low) clears the camera and light
// positions to zero and empties the pipeline; no clearing pass is needed.
module phong_fragment_lighting_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfl_pkg::POS_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pfl_pkg::pos_t                     s_frag_pos_x,
    input  pfl_pkg::pos_t                     s_frag_pos_y,
    input  pfl_pkg::pos_t                     s_frag_pos_z,
    input  pfl_pkg::nrm_t                     s_normal_x,
    input  pfl_pkg::nrm_t                     s_normal_y,
    input  pfl_pkg::nrm_t                     s_normal_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pfl_pkg::col_t                     m_red,
    output pfl_pkg::col_t                     m_green_out,
    output pfl_pkg::col_t                     m_blue
);
    import pfl_pkg::*;

    typedef struct packed {
        logic [2:0][UNIT_W-1:0] v;
        ufrac_t                 d;
        ufrac_t                 td;
    } rside_t;

    pos_t cam_reg   [3];
    pos_t light_reg [3];
    pos_t pos_in    [3];
    nrm_t nrm_in    [3];

    logic en, push;

    // input stage
    vec_t raw_n_reg [3];
    vec_t raw_v_reg [3];
    vec_t raw_l_reg [3];
    logic vld0_reg;

    // normaliser outputs
    unit_t n_u [3];
    unit_t v_u [3];
    unit_t l_u [3];
    unit_t r_u [3];
    logic  nv_vld, vv_vld, lv_vld, rv_vld;

    // diffuse and reflection stages
    vec_t   nl1_reg [3];
    unit_t  n1_reg [3], l1_reg [3], v1_reg [3];
    ufrac_t t1_reg;
    ufrac_t d2_reg, t2_reg;
    unit_t  n2_reg [3], l2_reg [3], v2_reg [3];
    vec_t   dn3_reg [3];
    ufrac_t d3_reg, td3_reg;
    unit_t  l3_reg [3], v3_reg [3];
    vec_t   rr4_reg [3];
    rside_t side4_reg;
    rside_t rside_reg [NORM_LAT];
    logic   vld1_reg, vld2_reg, vld3_reg, vld4_reg;

    // specular dot
    vec_t   vr5_reg [3];
    ufrac_t d5_reg, td5_reg, s6_reg, d6_reg, td6_reg;
    logic   vld5_reg, vld6_reg;

    // output side
    logic sp_vld;
    col_t sp_red, sp_green, sp_blue;
    logic m_valid_reg, skid_vld_reg;
    col_t red_reg, green_reg, blue_reg;
    col_t skid_red_reg, skid_green_reg, skid_blue_reg;

    assign pos_in[0] = s_frag_pos_x;
    assign pos_in[1] = s_frag_pos_y;
    assign pos_in[2] = s_frag_pos_z;
    assign nrm_in[0] = s_normal_x;
    assign nrm_in[1] = s_normal_y;
    assign nrm_in[2] = s_normal_z;

    // pipeline advances unless the skid buffer is occupied
    assign en        = !skid_vld_reg;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign push      = sp_vld && en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_reg   <= '{default: '0};
            light_reg <= '{default: '0};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CAMERA_X: cam_reg[0]   <= cfg_data;
                CFG_CAMERA_Y: cam_reg[1]   <= cfg_data;
                CFG_CAMERA_Z: cam_reg[2]   <= cfg_data;
                CFG_LIGHT_X:  light_reg[0] <= cfg_data;
                CFG_LIGHT_Y:  light_reg[1] <= cfg_data;
                CFG_LIGHT_Z:  light_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // datapath, all stages move on en
    always_ff @(posedge aclk) begin
        if (en) begin
            // raw normal, view and light vectors
            for (int c = 0; c < 3; c++) begin
                raw_n_reg[c] <= VEC_W'(nrm_in[c]);
                raw_v_reg[c] <= VEC_W'(cam_reg[c]) - VEC_W'(pos_in[c]);
                raw_l_reg[c] <= VEC_W'(light_reg[c]) - VEC_W'(pos_in[c]);
            end

            // N.L products, colour mix factor from normal y
            for (int c = 0; c < 3; c++) begin
                nl1_reg[c] <= VEC_W'(n_u[c]) * VEC_W'(l_u[c]);
                n1_reg[c]  <= n_u[c];
                l1_reg[c]  <= l_u[c];
                v1_reg[c]  <= v_u[c];
            end
            t1_reg <= (n_u[1] > 0) ? round_mul(n_u[1][Q_W-1:0], n_u[1][Q_W-1:0]) : '0;

            // clamped diffuse factor
            d2_reg <= clamp_dot(nl1_reg[0] + nl1_reg[1] + nl1_reg[2]);
            t2_reg <= t1_reg;
            n2_reg <= n1_reg;
            l2_reg <= l1_reg;
            v2_reg <= v1_reg;

            // d * N, t * d
            for (int c = 0; c < 3; c++) begin
                dn3_reg[c] <= VEC_W'($signed({1'b0, d2_reg})) * VEC_W'(n2_reg[c]);
            end
            td3_reg <= round_mul(t2_reg, d2_reg);
            d3_reg  <= d2_reg;
            l3_reg  <= l2_reg;
            v3_reg  <= v2_reg;

            // unnormalised reflection 2dN - L
            for (int c = 0; c < 3; c++) begin
                rr4_reg[c]     <= (dn3_reg[c] <<< 1) - (VEC_W'(l3_reg[c]) <<< FRAC_W);
                side4_reg.v[c] <= v3_reg[c];
            end
            side4_reg.d  <= d3_reg;
            side4_reg.td <= td3_reg;

            // side data waits for the reflection normaliser
            rside_reg[0] <= side4_reg;
            for (int i = 1; i < NORM_LAT; i++) begin
                rside_reg[i] <= rside_reg[i-1];
            end

            // V.R
            for (int c = 0; c < 3; c++) begin
                vr5_reg[c] <= VEC_W'($signed(rside_reg[NORM_LAT-1].v[c])) * VEC_W'(r_u[c]);
            end
            d5_reg  <= rside_reg[NORM_LAT-1].d;
            td5_reg <= rside_reg[NORM_LAT-1].td;

            s6_reg  <= clamp_dot(vr5_reg[0] + vr5_reg[1] + vr5_reg[2]);
            d6_reg  <= d5_reg;
            td6_reg <= td5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= s_valid;
            vld1_reg <= nv_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= rv_vld;
            vld6_reg <= vld5_reg;
        end
    end

    pfl_norm3 u_norm_n (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (vld0_reg),
        .in_x    (raw_n_reg[0]),
        .in_y    (raw_n_reg[1]),
        .in_z    (raw_n_reg[2]),
        .out_vld (nv_vld),
        .out_x   (n_u[0]),
        .out_y   (n_u[1]),
        .out_z   (n_u[2])
    );

    pfl_norm3 u_norm_v (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (vld0_reg),
        .in_x    (raw_v_reg[0]),
        .in_y    (raw_v_reg[1]),
        .in_z    (raw_v_reg[2]),
        .out_vld (vv_vld),
        .out_x   (v_u[0]),
        .out_y   (v_u[1]),
        .out_z   (v_u[2])
    );

    pfl_norm3 u_norm_l (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (vld0_reg),
        .in_x    (raw_l_reg[0]),
        .in_y    (raw_l_reg[1]),
        .in_z    (raw_l_reg[2]),
        .out_vld (lv_vld),
        .out_x   (l_u[0]),
        .out_y   (l_u[1]),
        .out_z   (l_u[2])
    );

    pfl_norm3 u_norm_r (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (vld4_reg),
        .in_x    (rr4_reg[0]),
        .in_y    (rr4_reg[1]),
        .in_z    (rr4_reg[2]),
        .out_vld (rv_vld),
        .out_x   (r_u[0]),
        .out_y   (r_u[1]),
        .out_z   (r_u[2])
    );

    pfl_specular u_specular (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (vld6_reg),
        .in_s      (s6_reg),
        .in_d      (d6_reg),
        .in_td     (td6_reg),
        .out_vld   (sp_vld),
        .out_red   (sp_red),
        .out_green (sp_green),
        .out_blue  (sp_blue)
    );

    // output register and skid buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
            end
        end else if (push) begin
            skid_vld_reg <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                red_reg   <= skid_red_reg;
                green_reg <= skid_green_reg;
                blue_reg  <= skid_blue_reg;
            end else begin
                red_reg   <= sp_red;
                green_reg <= sp_green;
                blue_reg  <= sp_blue;
            end
        end else if (push) begin
            skid_red_reg   <= sp_red;
            skid_green_reg <= sp_green;
            skid_blue_reg  <= sp_blue;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red       = red_reg;
    assign m_green_out = green_reg;
    assign m_blue      = blue_reg;

`ifndef NO_ASSERTIONS
    // the three first-pass normalisers run in lockstep
    a_norm_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        (nv_vld == vv_vld) && (nv_vld == lv_vld))
        else $error("normaliser valids out of step");

    // skid buffer only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_valid_reg)
        else $error("skid buffer full while output empty");

    // red and blue carry the same diffuse mix
    a_red_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_red == m_blue))
        else $error("red and blue differ");

    // sum of diffuse and specular stays within 2.0
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_red <= 18'd131072) && (m_green_out <= 18'd131072)))
        else $error("colour beyond 2.0");
`endif

endmodule
